FILE: hw/rtl/rskc_pkg.sv
// rskc_pkg: shared types, constants and helpers for the rms soft knee compressor
// used by rms_soft_knee_compressor_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rskc_pkg;

  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KNEE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL     = 3'd7;

  localparam logic signed [15:0] LEVEL_FLOOR     = -16'sd30720;
  localparam logic [17:0]        DB_PER_LOG2_Q16 = 18'd197283;
  localparam logic [17:0]        LOG2_PER_DB_Q20 = 18'd174165;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_L0,
    ST_L1,
    ST_L2,
    ST_L3,
    ST_LNORM,
    ST_NORM,
    ST_LOG,
    ST_DB,
    ST_CURVE,
    ST_USQ,
    ST_UNS,
    ST_DIV,
    ST_HARD,
    ST_SM0,
    ST_SM1,
    ST_GAIN,
    ST_EXP,
    ST_FIN,
    ST_OUT
  } state_t;

  // 2^(2^-(k+1)) in q1.30, k = 0..11; 1.0 for larger k
  function automatic logic [30:0] exp_step(input logic [3:0] k);
    logic [30:0] r;
    unique case (k)
      4'd0:    r = 31'd1518500250;
      4'd1:    r = 31'd1276901417;
      4'd2:    r = 31'd1170923762;
      4'd3:    r = 31'd1121280436;
      4'd4:    r = 31'd1097253708;
      4'd5:    r = 31'd1085434106;
      4'd6:    r = 31'd1079572136;
      4'd7:    r = 31'd1076653033;
      4'd8:    r = 31'd1075196443;
      4'd9:    r = 31'd1074468888;
      4'd10:   r = 31'd1074105294;
      4'd11:   r = 31'd1073923544;
      default: r = 31'd1073741824;
    endcase
    return r;
  endfunction

  // shift right by a constant, rounded half away from zero
  function automatic logic signed [67:0] rdiv_p2(input logic signed [67:0] v,
                                                 input int unsigned sh);
    logic signed [67:0] half;
    logic signed [67:0] r;
    half = 68'sd1 <<< (sh - 1);
    if (v >= 0) begin
      r = (v + half) >>> sh;
    end else begin
      r = -((-v + half) >>> sh);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rms_soft_knee_compressor_unit.sv
// rms_soft_knee_compressor_unit: per-channel rms compressor with soft knee
// one shared 34x34 multiplier under a sequencer; depends on rskc_pkg
// one item at a time: in_stall is high whenever the sequencer is not idle
// the next item is accepted after the result loads into the output register
// the work runs in series on the shared multiplier: 12 log squarings, 12 exp products,
// a normalize loop of 8 and 1 bit shifts, and the 13 step knee divider
// rst_n (synchronous) restores register defaults and zeros all channel state
`timescale 1ns / 1ps
`default_nettype none
module rms_soft_knee_compressor_unit #(
  parameter int CHANNELS    = rskc_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = rskc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [3:0]                           in_channel,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]             out_sample_out,
  input  wire logic                                 cfg_we,
  input  wire logic [rskc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rskc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rskc_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SB   = SAMPLE_BITS;

  // configuration
  logic               bypass_r;
  logic signed [15:0] thr_r;
  logic [16:0]        inv_r;
  logic [12:0]        knee_r;
  logic signed [13:0] makeup_r;
  logic [15:0]        attack_r;
  logic [15:0]        release_r;
  logic [15:0]        level_r;

  // channel state
  logic [47:0]        ms_mem [CHANNELS];
  logic signed [31:0] g_mem  [CHANNELS];

  state_t state_r, state_nxt;

  logic [CH_W-1:0]        ch_r, ch_nxt;
  logic signed [SB-1:0]   x_r, x_nxt;
  logic [46:0]            sq_r, sq_nxt;
  logic signed [66:0]     acc_r, acc_nxt;
  logic [47:0]            nm_r, nm_nxt;
  logic [5:0]             p_r, p_nxt;
  logic [31:0]            lm_r, lm_nxt;
  logic signed [18:0]     l2_r, l2_nxt;
  logic [3:0]             cnt_r, cnt_nxt;
  logic signed [15:0]     lvl_r, lvl_nxt;
  logic [14:0]            u_r, u_nxt;
  logic [27:0]            u2_r, u2_nxt;
  logic [13:0]            rem_r, rem_nxt;
  logic [12:0]            dq_r, dq_nxt;
  logic signed [24:0]     t_r, t_nxt;
  logic [15:0]            c_r, c_nxt;
  logic signed [31:0]     g_r, g_nxt;
  logic [11:0]            f_r, f_nxt;
  logic signed [18:0]     s_r, s_nxt;
  logic [31:0]            em_r, em_nxt;
  logic signed [SB-1:0]   res_r, res_nxt;
  logic                   out_valid_r;
  logic signed [SB-1:0]   out_data_r;

  logic                   ms_we, g_we;
  logic [47:0]            ms_new;
  logic signed [33:0]     mul_a, mul_b;
  logic signed [67:0]     mul_p;

  logic [47:0]            ms_cur;
  logic signed [31:0]     g_cur;
  logic [SB-1:0]          ax;
  logic [31:0]            a32;
  logic [23:0]            a24;
  logic [16:0]            lc_inv;
  logic [16:0]            ns;
  logic signed [18:0]     over;
  logic signed [18:0]     over2;
  logic signed [18:0]     ksg;
  logic                   out_free;

  logic signed [67:0]     tmp;
  logic [31:0]            mm;
  logic [14:0]            trial;
  logic                   qbit;
  logic signed [33:0]     tot;
  logic signed [29:0]     e_v;
  logic signed [17:0]     n_v;
  logic [3:0]             fidx;
  logic [63:0]            prod;
  logic [63:0]            rr;
  logic [63:0]            lim;
  logic [5:0]             sh;
  logic signed [18:0]     pe;

  assign mul_p    = mul_a * mul_b;
  assign ms_cur   = ms_mem[ch_r];
  assign g_cur    = g_mem[ch_r];
  assign ax       = x_r[SB-1] ? SB'(-x_r) : SB'(x_r);
  assign a32      = 32'(ax) << (32 - SB);
  assign a24      = a32[31:8];
  assign lc_inv   = 17'd65536 - 17'(level_r);
  assign ns       = (inv_r > 17'd65536) ? 17'd0 : 17'd65536 - inv_r;
  assign over     = 19'(lvl_r) - 19'(thr_r);
  assign over2    = over <<< 1;
  assign ksg      = signed'(19'(knee_r));
  assign lim      = 64'(1) << (SB - 1);
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r  <= 1'b0;
      thr_r     <= -16'sd5120;
      inv_r     <= 17'd16384;
      knee_r    <= 13'd1536;
      makeup_r  <= 14'sd0;
      attack_r  <= 16'd62259;
      release_r <= 16'd65076;
      level_r   <= 16'd65505;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BYPASS:    bypass_r  <= cfg_wdata[0];
        CFG_THRESHOLD: thr_r     <= signed'(cfg_wdata[15:0]);
        CFG_INV_RATIO: inv_r     <= cfg_wdata[16:0];
        CFG_KNEE:      knee_r    <= cfg_wdata[12:0];
        CFG_MAKEUP:    makeup_r  <= signed'(cfg_wdata[13:0]);
        CFG_ATTACK:    attack_r  <= cfg_wdata[15:0];
        CFG_RELEASE:   release_r <= cfg_wdata[15:0];
        CFG_LEVEL:     level_r   <= cfg_wdata[15:0];
        default:       bypass_r  <= bypass_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ms_mem[i] <= '0;
        g_mem[i]  <= '0;
      end
    end else begin
      if (ms_we) begin
        ms_mem[ch_r] <= ms_new;
      end
      if (g_we) begin
        g_mem[ch_r] <= g_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_data_r <= res_r;
    end
    ch_r  <= ch_nxt;
    x_r   <= x_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
    nm_r  <= nm_nxt;
    p_r   <= p_nxt;
    lm_r  <= lm_nxt;
    l2_r  <= l2_nxt;
    cnt_r <= cnt_nxt;
    lvl_r <= lvl_nxt;
    u_r   <= u_nxt;
    u2_r  <= u2_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    t_r   <= t_nxt;
    c_r   <= c_nxt;
    g_r   <= g_nxt;
    f_r   <= f_nxt;
    s_r   <= s_nxt;
    em_r  <= em_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    x_nxt     = x_r;
    sq_nxt    = sq_r;
    acc_nxt   = acc_r;
    nm_nxt    = nm_r;
    p_nxt     = p_r;
    lm_nxt    = lm_r;
    l2_nxt    = l2_r;
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    u_nxt     = u_r;
    u2_nxt    = u2_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    t_nxt     = t_r;
    c_nxt     = c_r;
    g_nxt     = g_r;
    f_nxt     = f_r;
    s_nxt     = s_r;
    em_nxt    = em_r;
    res_nxt   = res_r;
    ms_we     = 1'b0;
    g_we      = 1'b0;
    ms_new    = '0;
    mul_a     = '0;
    mul_b     = '0;
    tmp       = '0;
    mm        = '0;
    trial     = '0;
    qbit      = 1'b0;
    tot       = '0;
    e_v       = '0;
    n_v       = '0;
    fidx      = '0;
    prod      = '0;
    rr        = '0;
    sh        = '0;
    pe        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (bypass_r) begin
            res_nxt   = in_sample_in;
            state_nxt = ST_OUT;
          end else begin
            ch_nxt    = (in_channel > 4'(CHANNELS - 1)) ? CH_W'(CHANNELS - 1)
                                                          : CH_W'(in_channel);
            x_nxt     = in_sample_in;
            state_nxt = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        mul_a     = 34'(a24);
        mul_b     = 34'(a24);
        sq_nxt    = mul_p[46:0];
        state_nxt = ST_L0;
      end
      ST_L0: begin
        mul_a     = 34'(level_r);
        mul_b     = 34'(ms_cur[23:0]);
        acc_nxt   = mul_p[66:0];
        state_nxt = ST_L1;
      end
      ST_L1: begin
        mul_a     = 34'(level_r);
        mul_b     = 34'(ms_cur[47:24]);
        acc_nxt   = acc_r + (mul_p[66:0] <<< 24);
        state_nxt = ST_L2;
      end
      ST_L2: begin
        mul_a     = 34'(lc_inv);
        mul_b     = 34'(sq_r[23:0]);
        acc_nxt   = acc_r + mul_p[66:0];
        state_nxt = ST_L3;
      end
      ST_L3: begin
        mul_a     = 34'(lc_inv);
        mul_b     = 34'(sq_r[46:24]);
        acc_nxt   = acc_r + (mul_p[66:0] <<< 24);
        state_nxt = ST_LNORM;
      end
      ST_LNORM: begin
        tmp    = 68'(acc_r) + 68'sd32768;
        ms_new = tmp[63:16];
        ms_we  = 1'b1;
        if (ms_new == '0) begin
          lvl_nxt   = LEVEL_FLOOR;
          state_nxt = ST_CURVE;
        end else begin
          nm_nxt    = ms_new;
          p_nxt     = 6'd47;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (nm_r[47]) begin
          lm_nxt    = 32'(nm_r[47:17]);
          pe        = signed'(19'(p_r)) - 19'sd46;
          l2_nxt    = pe <<< 12;
          cnt_nxt   = 4'd11;
          state_nxt = ST_LOG;
        end else if (nm_r[47:40] == '0) begin
          nm_nxt = nm_r << 8;
          p_nxt  = p_r - 6'd8;
        end else begin
          nm_nxt = nm_r << 1;
          p_nxt  = p_r - 6'd1;
        end
      end
      ST_LOG: begin
        mul_a = 34'(lm_r);
        mul_b = 34'(lm_r);
        mm    = mul_p[61:30];
        if (mm[31]) begin
          l2_nxt = l2_r + (19'sd1 <<< cnt_r);
          lm_nxt = mm >> 1;
        end else begin
          lm_nxt = mm;
        end
        if (cnt_r == '0) begin
          state_nxt = ST_DB;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      ST_DB: begin
        mul_a     = 34'(l2_r);
        mul_b     = 34'(DB_PER_LOG2_Q16);
        tmp       = rdiv_p2(mul_p, 20);
        lvl_nxt   = (tmp < 68'(LEVEL_FLOOR)) ? LEVEL_FLOOR : tmp[15:0];
        state_nxt = ST_CURVE;
      end
      ST_CURVE: begin
        if (knee_r != '0 && over2 > -ksg && over2 < ksg) begin
          u_nxt     = 15'(over2 + ksg);
          state_nxt = ST_USQ;
        end else if (over2 >= ksg && over > 0) begin
          state_nxt = ST_HARD;
        end else begin
          t_nxt     = '0;
          state_nxt = ST_SM0;
        end
      end
      ST_USQ: begin
        mul_a     = 34'(u_r);
        mul_b     = 34'(u_r);
        u2_nxt    = mul_p[27:0];
        state_nxt = ST_UNS;
      end
      ST_UNS: begin
        mul_a     = 34'(ns);
        mul_b     = 34'(u2_r);
        tmp       = (mul_p + (68'(knee_r) <<< 18)) >>> 19;
        rem_nxt   = tmp[26:13];
        dq_nxt    = tmp[12:0];
        cnt_nxt   = 4'd12;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        trial = {rem_r, dq_r[12]};
        if (trial >= 15'(knee_r)) begin
          trial = trial - 15'(knee_r);
          qbit  = 1'b1;
        end
        rem_nxt = trial[13:0];
        dq_nxt  = {dq_r[11:0], qbit};
        if (cnt_r == '0) begin
          t_nxt     = -(signed'(25'(dq_nxt)) <<< 8);
          state_nxt = ST_SM0;
        end else begin
          cnt_nxt = cnt_r - 4'd1;
        end
      end
      ST_HARD: begin
        mul_a     = 34'(ns);
        mul_b     = 34'(over);
        tmp       = (mul_p + 68'sd32768) >>> 16;
        t_nxt     = -(25'(tmp) <<< 8);
        state_nxt = ST_SM0;
      end
      ST_SM0: begin
        c_nxt     = (32'(t_r) < g_cur) ? attack_r : release_r;
        mul_a     = 34'(c_nxt);
        mul_b     = 34'(g_cur);
        acc_nxt   = mul_p[66:0];
        state_nxt = ST_SM1;
      end
      ST_SM1: begin
        mul_a     = 34'(17'd65536 - 17'(c_r));
        mul_b     = 34'(t_r);
        tmp       = rdiv_p2(68'(acc_r) + mul_p, 16);
        g_nxt     = tmp[31:0];
        g_we      = 1'b1;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        tot       = 34'(g_r) + (34'(makeup_r) <<< 8);
        mul_a     = tot;
        mul_b     = 34'(LOG2_PER_DB_Q20);
        tmp       = rdiv_p2(mul_p, 24);
        e_v       = tmp[29:0];
        f_nxt     = e_v[11:0];
        n_v       = 18'(e_v >>> 12);
        s_nxt     = 19'sd30 - 19'(n_v);
        em_nxt    = 32'd1 << 30;
        cnt_nxt   = '0;
        state_nxt = ST_EXP;
      end
      ST_EXP: begin
        fidx   = 4'd11 - cnt_r;
        mul_a  = 34'(em_r);
        mul_b  = f_r[fidx] ? 34'(exp_step(cnt_r)) : (34'sd1 <<< 30);
        tmp    = (mul_p + (68'sd1 <<< 29)) >>> 30;
        em_nxt = tmp[31:0];
        if (cnt_r == 4'd11) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_FIN: begin
        mul_a = 34'(ax);
        mul_b = 34'(em_r);
        prod  = mul_p[63:0];
        if (ax == '0 || s_r >= 19'sd63) begin
          res_nxt = '0;
        end else if (s_r <= 19'sd0) begin
          res_nxt = x_r[SB-1] ? SB'(-lim) : SB'(lim - 64'd1);
        end else begin
          sh = 6'(s_r - 19'sd1);
          rr = ((prod >> sh) + 64'd1) >> 1;
          if (x_r[SB-1]) begin
            res_nxt = (rr > lim) ? SB'(-lim) : SB'(-rr);
          end else begin
            res_nxt = (rr > lim - 64'd1) ? SB'(lim - 64'd1) : SB'(rr);
          end
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> knee_r != '0)
    else $error("knee divider running with zero width");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NORM |-> nm_r != '0)
    else $error("normalize loop on zero level");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXP |-> !em_r[31])
    else $error("exp mantissa reached two");

  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> state_r == ST_OUT)
    else $error("result step skipped output stage");

endmodule
`default_nettype wire
